/* hw/rtl/aes256_pkg.sv */
// Shared types, constants and round functions for the AES-256 cipher pipeline.
package aes256_pkg;

  localparam int ROUND_COUNT = 14;
  localparam int KEY_WORDS   = 2 * (ROUND_COUNT + 1);
  localparam int KIDX_W      = 5;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic decrypt;
  } stage_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = t[x];
  endfunction

  function automatic logic [7:0] sbox_rev(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    sbox_rev = t[x];
  endfunction

  // byte k of the state sits at bits 127-8k
  function automatic logic [7:0] st_byte(input logic [127:0] s, input int k);
    st_byte = s[127 - 8*k -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (!inv) begin
          src = r + 4 * ((c + r) % 4);
          t[127 - 8*(r + 4*c) -: 8] = sbox(st_byte(s, src));
        end else begin
          src = r + 4 * ((c + 4 - r) % 4);
          t[127 - 8*(r + 4*c) -: 8] = sbox_rev(st_byte(s, src));
        end
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] col [4];
    logic [7:0] o;
    logic [7:0] m [4];
    t = '0;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else     m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = st_byte(s, r + 4*c);
      for (int r = 0; r < 4; r++) begin
        o = 8'h00;
        for (int k = 0; k < 4; k++) o = o ^ gmul(m[(k - r + 4) % 4], col[k]);
        t[127 - 8*(r + 4*c) -: 8] = o;
      end
    end
    mix = t;
  endfunction

endpackage

/* hw/rtl/aes256_block_cipher_top.sv */
// Top level: command decode, key store and unrolled round pipeline.
//
//  channel  | signals                                        | handshake
//  command  | command key_word_index key_word block_hi/lo    | start & !busy
//  result   | result_hi result_lo was_decrypt                | done strobe
//
// One block enters per cycle; each result is registered by the initial key add
// stage and then by one register per round.
// busy is always low: the round pipeline never stalls and results are not held.
// rst clears the valid bits only; the key store is undefined until loaded.
module aes256_block_cipher_top
  import aes256_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [KIDX_W-1:0] key_word_index,
  input  logic [63:0]       key_word,
  input  logic [63:0]       block_hi,
  input  logic [63:0]       block_lo,
  output logic              done,
  output logic [63:0]       result_hi,
  output logic [63:0]       result_lo,
  output logic              was_decrypt
);

  logic [KEY_WORDS*64-1:0] keys;
  stage_ctl_t              ctl   [ROUND_COUNT+1];
  logic [127:0]            st    [ROUND_COUNT+1];
  cmd_t                    cmd;
  logic                    is_dec;

  assign busy   = 1'b0;
  assign cmd    = cmd_t'(command);
  assign is_dec = (cmd == CMD_DECRYPT);

  aes256_key_store u_keys (
    .clk   (clk),
    .we    (start && cmd == CMD_LOAD),
    .widx  (key_word_index),
    .wdata (key_word),
    .keys  (keys)
  );

  // initial key add stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= start && (cmd == CMD_ENCRYPT || cmd == CMD_DECRYPT);
    end
    ctl[0].decrypt <= is_dec;
    st[0] <= {block_hi, block_lo} ^ (is_dec
             ? {keys[(2*ROUND_COUNT)*64 +: 64], keys[(2*ROUND_COUNT+1)*64 +: 64]}
             : {keys[0 +: 64], keys[64 +: 64]});
  end

  for (genvar r = 1; r <= ROUND_COUNT; r++) begin : g_round
    aes256_round u_round (
      .clk       (clk),
      .rst       (rst),
      .ctl_in    (ctl[r-1]),
      .state_in  (st[r-1]),
      .key_enc   ({keys[(2*r)*64 +: 64], keys[(2*r+1)*64 +: 64]}),
      .key_dec   ({keys[(2*(ROUND_COUNT-r))*64 +: 64],
                   keys[(2*(ROUND_COUNT-r)+1)*64 +: 64]}),
      .last      (r == ROUND_COUNT),
      .ctl_out   (ctl[r]),
      .state_out (st[r])
    );
  end

  assign done        = ctl[ROUND_COUNT].valid;
  assign was_decrypt = ctl[ROUND_COUNT].decrypt;
  assign result_hi   = st[ROUND_COUNT][127:64];
  assign result_lo   = st[ROUND_COUNT][63:0];

endmodule

/* hw/rtl/aes256_key_store.sv */
// Round key store: one flop row per 64-bit key word, two rows per round key, written one word per load.
module aes256_key_store
  import aes256_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [KIDX_W-1:0]     widx,
  input  logic [63:0]           wdata,
  output logic [KEY_WORDS*64-1:0] keys
);

  logic [63:0] mem [KEY_WORDS];

  always_ff @(posedge clk) begin
    if (we && widx < KIDX_W'(KEY_WORDS)) begin
      mem[widx] <= wdata;
    end
  end

  // each word sits at its own fixed place on the keys bus
  always_comb begin
    for (int i = 0; i < KEY_WORDS; i++) keys[i*64 +: 64] = mem[i];
  end

endmodule

/* hw/rtl/aes256_round.sv */
// One registered cipher round for both directions.
module aes256_round
  import aes256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  stage_ctl_t   ctl_in,
  input  logic [127:0] state_in,
  input  logic [127:0] key_enc,
  input  logic [127:0] key_dec,
  input  logic         last,
  output stage_ctl_t   ctl_out,
  output logic [127:0] state_out
);

  logic [127:0] ss;
  logic [127:0] state_next;

  always_comb begin
    ss = sub_shift(state_in, ctl_in.decrypt);
    if (ctl_in.decrypt) begin
      // inverse: add key, then inverse mix unless last
      state_next = last ? (ss ^ key_dec) : mix(ss ^ key_dec, 1'b1);
    end else begin
      state_next = last ? (ss ^ key_enc) : (mix(ss, 1'b0) ^ key_enc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.decrypt <= ctl_in.decrypt;
    state_out       <= state_next;
  end

endmodule
